// ===== design/rbsi_pkg.sv =====
// ----------------------------------------------------------------------------
// Ray box slab package
// Shared widths, axis codes and types for the segment versus box slab test.
// ----------------------------------------------------------------------------
package rbsi_pkg;

  localparam int CoordW = 24;
  localparam int DiffW  = 26;
  localparam int FracW  = 17;
  localparam int QuotW  = 16;
  localparam int ProdW  = 2 * DiffW;
  localparam int InW    = 12 * CoordW;
  localparam int OutW   = 24;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic               skip;
    logic               miss;
    logic               neg;
    logic [DiffW-1:0]   den;
    logic signed [DiffW-1:0] n0;
    logic signed [DiffW-1:0] n1;
  } slab_t;

  typedef struct packed {
    logic                    dead;
    logic [1:0]              axis;
    logic                    neg;
    logic signed [DiffW-1:0] mn_num;
    logic [DiffW-1:0]        mn_den;
    logic signed [DiffW-1:0] mx_num;
    logic [DiffW-1:0]        mx_den;
  } window_t;

endpackage

// ===== design/rbsi_slab.sv =====
// ----------------------------------------------------------------------------
// Slab setup
// Per axis differences, sign fix of the denominator and ordering of times.
// ----------------------------------------------------------------------------
module rbsi_slab import rbsi_pkg::*; (
  input  logic signed [CoordW-1:0] s,
  input  logic signed [CoordW-1:0] e,
  input  logic signed [CoordW-1:0] lo,
  input  logic signed [CoordW-1:0] hi,
  output slab_t                    slab
);

  logic signed [DiffW-1:0] d;
  logic signed [DiffW-1:0] a;
  logic signed [DiffW-1:0] b;

  always_comb begin
    d = DiffW'(e) - DiffW'(s);
    a = DiffW'(lo) - DiffW'(s);
    b = DiffW'(hi) - DiffW'(s);
    slab.skip = (d == '0);
    slab.miss = (s < lo) || (s > hi);
    if (d < 0) begin
      d = -d;
      a = -a;
      b = -b;
    end
    slab.den = d;
    if (a > b) begin
      slab.n0 = b;
      slab.n1 = a;
      slab.neg = 1'b0;
    end else begin
      slab.n0 = a;
      slab.n1 = b;
      slab.neg = 1'b1;
    end
  end

endmodule

// ===== design/rbsi_narrow.sv =====
// ----------------------------------------------------------------------------
// Window narrowing stage
// Two registered cross multiply stages that fold one slab into the window.
// ----------------------------------------------------------------------------
module rbsi_narrow import rbsi_pkg::*; (
  input  logic         clk,
  input  logic         en,
  input  logic [1:0]   axis,
  input  window_t      win_in,
  input  slab_t        slab_in,
  output window_t      win_out
);

  window_t                 w1;
  slab_t                   s1;
  logic                    gt_min;
  logic                    lt_max;
  logic signed [ProdW-1:0] p0;
  logic signed [ProdW-1:0] p1;
  logic signed [ProdW-1:0] p2;
  logic signed [ProdW-1:0] p3;
  window_t                 w2;
  logic signed [ProdW-1:0] q0;
  logic signed [ProdW-1:0] q1;
  window_t                 nx;

  always_comb begin
    p0 = ProdW'(slab_in.n0) * $signed({1'b0, win_in.mn_den});
    p1 = ProdW'(win_in.mn_num) * $signed({1'b0, slab_in.den});
    p2 = ProdW'(win_in.mx_num) * $signed({1'b0, slab_in.den});
    p3 = ProdW'(slab_in.n1) * $signed({1'b0, win_in.mx_den});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1 <= win_in;
      s1 <= slab_in;
      gt_min <= p0 > p1;
      lt_max <= p2 > p3;
    end
  end

  always_comb begin
    w2 = w1;
    if (!s1.skip) begin
      if (gt_min) begin
        w2.mn_num = s1.n0;
        w2.mn_den = s1.den;
        w2.axis = axis;
        w2.neg = s1.neg;
      end
      if (lt_max) begin
        w2.mx_num = s1.n1;
        w2.mx_den = s1.den;
      end
    end else if (s1.miss) begin
      w2.dead = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx <= w2;
      q0 <= ProdW'(w2.mn_num) * $signed({1'b0, w2.mx_den});
      q1 <= ProdW'(w2.mx_num) * $signed({1'b0, w2.mn_den});
    end
  end

  always_comb begin
    win_out = nx;
    if (q0 > q1) begin
      win_out.dead = 1'b1;
    end
  end

endmodule

// ===== design/rbsi_divide.sv =====
// ----------------------------------------------------------------------------
// Pipelined fraction divider
// Restoring division, one quotient bit per stage, for floor(num * 2^16 / den).
// ----------------------------------------------------------------------------
module rbsi_divide import rbsi_pkg::*; #(
  parameter int Tag = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DiffW-1:0] num,
  input  logic [DiffW-1:0] den,
  input  logic [Tag-1:0]   tag_in,
  output logic [FracW-1:0] quot,
  output logic [Tag-1:0]   tag_out
);

  localparam int Steps = FracW;
  localparam int RemW  = DiffW + 1;

  logic [RemW-1:0]  rem [Steps+1];
  logic [DiffW-1:0] dv  [Steps+1];
  logic [FracW-1:0] qq  [Steps+1];
  logic [Tag-1:0]   tg  [Steps+1];
  logic [RemW-1:0]  sh  [Steps];

  always_comb begin
    rem[0] = '0;
    qq[0] = '0;
    dv[0] = den;
    tg[0] = tag_in;
  end

  // The integer part is at most one since num is at most den.
  for (genvar k = 0; k < Steps; k++) begin : g_step
    always_comb begin
      if (k == 0) begin
        sh[k] = RemW'(num);
      end else begin
        sh[k] = {rem[k][RemW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv[k+1] <= dv[k];
        tg[k+1] <= tg[k];
        if (sh[k] >= RemW'(dv[k])) begin
          rem[k+1] <= sh[k] - RemW'(dv[k]);
          qq[k+1] <= {qq[k][FracW-2:0], 1'b1};
        end else begin
          rem[k+1] <= sh[k];
          qq[k+1] <= {qq[k][FracW-2:0], 1'b0};
        end
      end
    end
  end

  assign quot = qq[Steps];
  assign tag_out = tg[Steps];

endmodule

// ===== design/ray_box_slab_intersect.sv =====
// ----------------------------------------------------------------------------
// Segment versus box slab intersection
// Streaming slab test of one segment against one axis-aligned box per transfer.
// ----------------------------------------------------------------------------
// One transfer is accepted every cycle unless the output stalls. The pipeline has
// one setup stage, two stages for each of the three axes and seventeen stages
// of the bit-per-stage entry fraction divider. The whole pipeline advances
// together and holds when the output stage is full and not taken.
module ray_box_slab_intersect import rbsi_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  // start_x, start_y, start_z, stop_x, stop_y, stop_z,
  // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z.
  input  logic [InW-1:0]  s_tdata,
  output logic            m_tvalid,
  input  logic            m_tready,
  // hit, entry_fraction, normal_axis, normal_negative, zero fill.
  output logic [OutW-1:0] m_tdata
);

  localparam int Lat = 1 + 6 + FracW;
  localparam int Tag = 4;

  logic            en;
  logic [Lat-1:0]  vld;
  slab_t           sl  [3];
  slab_t           sl_q [3];
  window_t         w   [4];
  logic [Tag-1:0]  tg_out;
  logic [FracW-1:0] q;
  logic [DiffW-1:0] dnum;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  for (genvar a = 0; a < 3; a++) begin : g_ax
    rbsi_slab u_slab (
      .s  (s_tdata[a*CoordW +: CoordW]),
      .e  (s_tdata[(3+a)*CoordW +: CoordW]),
      .lo (s_tdata[(6+a)*CoordW +: CoordW]),
      .hi (s_tdata[(9+a)*CoordW +: CoordW]),
      .slab (sl[a])
    );
  end

  // Later axes wait in delay registers until their narrowing stage.
  slab_t d_y1, d_y2, d_z1, d_z2, d_z3, d_z4;

  always_ff @(posedge clk) begin
    if (en) begin
      sl_q[0] <= sl[0];
      sl_q[1] <= sl[1];
      sl_q[2] <= sl[2];
      d_y1 <= sl_q[1];
      d_y2 <= d_y1;
      d_z1 <= sl_q[2];
      d_z2 <= d_z1;
      d_z3 <= d_z2;
      d_z4 <= d_z3;
    end
  end

  always_comb begin
    w[0] = '0;
    w[0].axis = AXIS_Z;
    w[0].mn_den = DiffW'(1);
    w[0].mx_num = DiffW'(1);
    w[0].mx_den = DiffW'(1);
  end

  rbsi_narrow u_nx (.clk, .en, .axis(AXIS_X), .win_in(w[0]), .slab_in(sl_q[0]),
                    .win_out(w[1]));
  rbsi_narrow u_ny (.clk, .en, .axis(AXIS_Y), .win_in(w[1]), .slab_in(d_y2),
                    .win_out(w[2]));
  rbsi_narrow u_nz (.clk, .en, .axis(AXIS_Z), .win_in(w[2]), .slab_in(d_z4),
                    .win_out(w[3]));

  assign dnum = w[3].mn_num[DiffW-1] ? '0 : w[3].mn_num;

  rbsi_divide #(.Tag(Tag)) u_div (
    .clk, .en,
    .num (dnum),
    .den (w[3].mn_den),
    .tag_in ({!w[3].dead, w[3].axis, w[3].neg}),
    .quot (q),
    .tag_out (tg_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], s_tvalid};
    end
  end

  assign m_tvalid = vld[Lat-1];

  always_comb begin
    m_tdata = '0;
    if (tg_out[3]) begin
      m_tdata[0] = 1'b1;
      m_tdata[FracW:1] = q;
      m_tdata[FracW+2:FracW+1] = tg_out[2:1];
      m_tdata[FracW+3] = tg_out[0];
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");
  a_frac: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[FracW:1] <= FracW'(65536))
    else $error("entry fraction above one");
  a_miss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[FracW+3:1] == '0)
    else $error("miss with nonzero fields");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

// ===== verif/ray_box_slab_intersect_checker.sv =====
// ----------------------------------------------------------------------------
// Slab test result checker
// Watches both stream channels, predicts each hit result from the accepted
// segment and box, and compares every result transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module ray_box_slab_intersect_checker import rbsi_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic            s_tready,
  input  logic [InW-1:0]  s_tdata,
  input  logic            m_tvalid,
  input  logic            m_tready,
  input  logic [OutW-1:0] m_tdata,
  output int              fail_count,
  output int              pending
);

  typedef struct packed {
    logic        hit;
    logic [16:0] frac;
    logic [1:0]  axis;
    logic        neg;
  } hit_result_t;

  hit_result_t expected_hits[$];

  function automatic hit_result_t slab_predict(input logic [InW-1:0] d);
    hit_result_t r;
    longint s, e, lo, hi, dl, n0, n1, den, tmp;
    longint mn_num, mn_den, mx_num, mx_den;
    logic [1:0] ax;
    logic ng, sneg;
    longint q;
    r = '0;
    mn_num = 0; mn_den = 1; mx_num = 1; mx_den = 1;
    ax = AXIS_Z; ng = 1'b0;
    for (int i = 0; i < 3; i++) begin
      s  = longint'($signed(d[i*CoordW +: CoordW]));
      e  = longint'($signed(d[(3+i)*CoordW +: CoordW]));
      lo = longint'($signed(d[(6+i)*CoordW +: CoordW]));
      hi = longint'($signed(d[(9+i)*CoordW +: CoordW]));
      dl = e - s;
      sneg = 1'b1;
      if (dl == 0) begin
        if (s < lo || s > hi) return r;
        continue;
      end
      n0 = lo - s; n1 = hi - s; den = dl;
      if (den < 0) begin
        den = -den; n0 = -n0; n1 = -n1;
      end
      if (n0 > n1) begin
        tmp = n0; n0 = n1; n1 = tmp; sneg = 1'b0;
      end
      if (n0 * mn_den > mn_num * den) begin
        mn_num = n0; mn_den = den; ax = 2'(i); ng = sneg;
      end
      if (mx_num * den > n1 * mx_den) begin
        mx_num = n1; mx_den = den;
      end
      if (mn_num * mx_den > mx_num * mn_den) return r;
    end
    q = (mn_num * 65536) / mn_den;
    if (q > 65536) q = 65536;
    r.hit = 1'b1; r.frac = 17'(q); r.axis = ax; r.neg = ng;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  assign pending = expected_hits.size();

  always @(posedge clk) begin
    hit_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) expected_hits.push_back(slab_predict(s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_hits.size() == 0) begin
          report_mismatch("unexpected result", m_tdata, 0);
        end else begin
          want = expected_hits.pop_front();
          if (m_tdata[0] !== want.hit) report_mismatch("hit", m_tdata[0], want.hit);
          if (m_tdata[17:1] !== want.frac)
            report_mismatch("entry_fraction", m_tdata[17:1], want.frac);
          if (m_tdata[19:18] !== want.axis)
            report_mismatch("normal_axis", m_tdata[19:18], want.axis);
          if (m_tdata[20] !== want.neg)
            report_mismatch("normal_negative", m_tdata[20], want.neg);
        end
      end
    end
  end

endmodule

// ===== verif/ray_box_slab_intersect_tb.sv =====
// ----------------------------------------------------------------------------
// Slab test regression bench
// Drives directed and random segment/box pairs with random gaps and stalls,
// including a long output hold-off and a drain pause, and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module ray_box_slab_intersect_tb import rbsi_pkg::*; ();

  logic            clk, rst;
  logic            s_tvalid, s_tready, m_tvalid, m_tready;
  logic [InW-1:0]  s_tdata;
  logic [OutW-1:0] m_tdata;
  int              fail_count, pending;
  int              cycle_count;
  int              rx_wait;
  bit              long_hold;

  ray_box_slab_intersect dut (.*);
  ray_box_slab_intersect_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [CoordW-1:0] rand_coord(input int mode);
    case (mode)
      0: return CoordW'($urandom);
      1: return CoordW'($urandom_range(0, 160)) - CoordW'(80);
      2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return CoordW'($urandom_range(0, 4000)) - CoordW'(2000);
    endcase
  endfunction

  function automatic logic [InW-1:0] make_item(input int mode);
    logic [InW-1:0] d;
    logic [CoordW-1:0] a, b;
    for (int i = 0; i < 12; i++) d[i*CoordW +: CoordW] = rand_coord(mode);
    for (int i = 0; i < 3; i++) begin
      a = d[(6+i)*CoordW +: CoordW]; b = d[(9+i)*CoordW +: CoordW];
      if ($urandom_range(0, 9) != 0 && $signed(a) > $signed(b)) begin
        d[(6+i)*CoordW +: CoordW] = b; d[(9+i)*CoordW +: CoordW] = a;
      end
      if ($urandom_range(0, 5) == 0) d[(3+i)*CoordW +: CoordW] = d[i*CoordW +: CoordW];
    end
    return d;
  endfunction

  function automatic logic [InW-1:0] pack_item(input int sx, sy, sz, ex, ey, ez,
                                               lx, ly, lz, hx, hy, hz);
    return {CoordW'(hz), CoordW'(hy), CoordW'(hx), CoordW'(lz), CoordW'(ly), CoordW'(lx),
            CoordW'(ez), CoordW'(ey), CoordW'(ex), CoordW'(sz), CoordW'(sy), CoordW'(sx)};
  endfunction

  task automatic send_item(input logic [InW-1:0] d);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst || long_hold) begin
      m_tready <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      rx_wait = $urandom_range(0, 13);
      if ($urandom_range(0, 2) == 0) rx_wait = 0;
      m_tready <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait = rx_wait - 1;
      m_tready <= (rx_wait == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    long_hold = 1'b0;
    repeat (300) @(posedge clk);
    long_hold <= 1'b1;
    repeat (150) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    int m;
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_item(pack_item(-80, 0, 0, 80, 0, 0, -8, -8, -8, 8, 8, 8));
    send_item(pack_item(80, 0, 0, -80, 0, 0, -8, -8, -8, 8, 8, 8));
    send_item(pack_item(0, -80, 0, 0, 80, 0, -8, -8, -8, 8, 8, 8));
    send_item(pack_item(0, 0, 80, 0, 0, -80, -8, -8, -8, 8, 8, 8));
    send_item(pack_item(0, 0, 0, 5, 3, 1, -8, -8, -8, 8, 8, 8));
    send_item(pack_item(50, 0, 0, 50, 80, 0, -8, -8, -8, 8, 8, 8));
    send_item(pack_item(-50, 0, 0, -50, 80, 0, -8, -8, -8, 8, 8, 8));
    send_item(pack_item(8, 8, 8, 8, 8, 8, -8, -8, -8, 8, 8, 8));
    send_item(pack_item(-80, 0, 0, 80, 0, 0, 8, -8, -8, -8, 8, 8));
    send_item(pack_item(-80, -80, 0, 80, 80, 0, -8, -8, -8, 8, 8, 8));
    send_item(pack_item(-80, 0, 0, -10, 0, 0, -8, -8, -8, 8, 8, 8));
    send_item(pack_item(-80, 0, 0, -8, 0, 0, -8, -8, -8, 8, 8, 8));
    send_item(pack_item(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                        -8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
    send_item(pack_item(8388607, -8388608, 0, -8388608, 8388607, 1,
                        -1, -1, -1, 1, 1, 1));
    send_item(pack_item(-3, 0, 0, 3, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item({InW{1'b1}});
    send_item('0);
    for (int n = 0; n < 600; n++) begin
      if (n == 300) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
      end
      m = $urandom_range(0, 9);
      send_item(make_item(m < 2 ? 0 : (m < 4 ? 1 : (m == 4 ? 2 : 3))));
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rbsi_pkg.sv
design/rbsi_slab.sv
design/rbsi_narrow.sv
design/rbsi_divide.sv
design/ray_box_slab_intersect.sv
verif/ray_box_slab_intersect_checker.sv
verif/ray_box_slab_intersect_tb.sv
